// File: rtl/sssp_pkg.sv
// Shared types and constants of the shortest path engine.
`default_nettype none
package sssp_pkg;

  localparam int NODE_W = 6;
  localparam int CNT_W  = 7;
  localparam int WGT_W  = 24;
  localparam int DIST_W = 32;

  // node indices are six bits wide, so the node table holds this many
  localparam int NODES = 64;
  localparam logic [CNT_W-1:0] NODE_LIMIT = 7'd64;

  localparam logic [DIST_W-1:0] DIST_UNREACHED = 32'hFFFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_CEILING   = 32'hFFFF_FFFE;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0] tail;
    logic [NODE_W-1:0] head;
    logic [WGT_W-1:0]  weight;
  } edge_t;

  typedef struct packed {
    logic [DIST_W-1:0] path_len;
    logic [NODE_W-1:0] pred;
    logic              has_pred;
  } node_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDOUT,
    S_INIT,
    S_SCAN,
    S_EREAD,
    S_ECHK,
    S_ECMP,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: rtl/sssp_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface sssp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [5:0] from_node;
  logic [5:0] to_node;
  logic [23:0] edge_weight;
  modport source (output valid, mode, from_node, to_node, edge_weight, input ready);
  modport sink (input valid, mode, from_node, to_node, edge_weight, output ready);
endinterface

interface sssp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] distance;
  logic [5:0]  parent_node;
  logic        parent_valid;
  logic [6:0]  reached_count;
  modport source (output valid, status, distance, parent_node, parent_valid, reached_count,
                  input ready);
  modport sink (input valid, status, distance, parent_node, parent_valid, reached_count,
                output ready);
endinterface
`default_nettype wire

// File: rtl/sssp_edge_store.sv
// Edge list memory: one write port, one registered read port.
`default_nettype none
module sssp_edge_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire sssp_pkg::edge_t wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output sssp_pkg::edge_t      rdata
);
  import sssp_pkg::*;

  edge_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/single_source_shortest_path.sv
// Top level: single-source shortest path engine over a stored edge list.
// Add, clear and out-of-range requests: result registered in the cycle after the transaction.
// Read: the node table read is registered, then the result is registered from it. One request in flight at a time.
// Run: each settle scan reads the node entries in index order, then each stored edge is read
//   once per settled node, through the single read ports of the node table and edge memory.
// Reset (rst_n synchronous, low): no edges, node count 64, all nodes unreached.
`default_nettype none
module single_source_shortest_path #(
  parameter int MAX_EDGES = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  sssp_in_if.sink         in_ch,
  sssp_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [6:0] cfg_wdata
);
  import sssp_pkg::*;

  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam logic [ECW-1:0] EDGE_LIMIT = ECW'(MAX_EDGES);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] nc_r;
  logic [ECW-1:0]   edges_r, edges_nxt;
  logic [NODES-1:0] valid_r, valid_nxt;      // node entry written since run start
  logic [NODES-1:0] settled_r, settled_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;              // scan issue counter
  logic             rdv_r, rdv_nxt;          // scan read data valid next cycle
  logic [NODE_W-1:0] rdidx_r, rdidx_nxt;
  logic [DIST_W-1:0] best_d_r, best_d_nxt;
  logic [NODE_W-1:0] best_idx_r, best_idx_nxt;
  logic             best_f_r, best_f_nxt;
  logic [NODE_W-1:0] pick_r, pick_nxt;
  logic [DIST_W-1:0] pick_d_r, pick_d_nxt;
  logic [CNT_W-1:0] reached_r, reached_nxt;
  logic [ECW-1:0]   e_r, e_nxt;
  logic [NODE_W-1:0] src_r, src_nxt;

  logic             out_v_r, out_v_nxt;
  logic [1:0]       o_status_r, o_status_nxt;
  logic [DIST_W-1:0] o_dist_r, o_dist_nxt;
  logic [NODE_W-1:0] o_par_r, o_par_nxt;
  logic             o_pval_r, o_pval_nxt;
  logic [CNT_W-1:0] o_cnt_r, o_cnt_nxt;

  // node table: distance, parent and parent flag per node
  node_t node_mem [NODES];
  node_t node_q;
  logic  node_we, node_re;
  logic [NODE_W-1:0] node_waddr, node_raddr;
  node_t node_wdata;

  logic  edge_we, edge_re;
  logic [EAW-1:0] edge_waddr, edge_raddr;
  edge_t edge_wdata, edge_q;

  logic [CNT_W-1:0] n_eff;
  logic             accept;
  logic             a_ok, b_ok;
  logic [DIST_W-1:0] eff_d;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] nd;

  sssp_edge_store #(.DEPTH(MAX_EDGES), .AW(EAW)) u_edges (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .re    (edge_re),
    .raddr (edge_raddr),
    .rdata (edge_q)
  );

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_q <= node_mem[node_raddr];
    end
  end

  // zero acts as one, anything above the table size as the table size
  assign n_eff = (nc_r == '0) ? CNT_W'(1) : ((nc_r > NODE_LIMIT) ? NODE_LIMIT : nc_r);

  assign in_ch.ready = (state_r == S_IDLE) && (!out_v_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign a_ok        = {1'b0, in_ch.from_node} < n_eff;
  assign b_ok        = {1'b0, in_ch.to_node} < n_eff;

  assign out_ch.valid         = out_v_r;
  assign out_ch.status        = o_status_r;
  assign out_ch.distance      = o_dist_r;
  assign out_ch.parent_node   = o_par_r;
  assign out_ch.parent_valid  = o_pval_r;
  assign out_ch.reached_count = o_cnt_r;

  always_comb begin
    state_nxt    = state_r;
    edges_nxt    = edges_r;
    valid_nxt    = valid_r;
    settled_nxt  = settled_r;
    i_nxt        = i_r;
    rdv_nxt      = 1'b0;
    rdidx_nxt    = rdidx_r;
    best_d_nxt   = best_d_r;
    best_idx_nxt = best_idx_r;
    best_f_nxt   = best_f_r;
    pick_nxt     = pick_r;
    pick_d_nxt   = pick_d_r;
    reached_nxt  = reached_r;
    e_nxt        = e_r;
    src_nxt      = src_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    o_status_nxt = o_status_r;
    o_dist_nxt   = o_dist_r;
    o_par_nxt    = o_par_r;
    o_pval_nxt   = o_pval_r;
    o_cnt_nxt    = o_cnt_r;
    node_we      = 1'b0;
    node_re      = 1'b0;
    node_waddr   = '0;
    node_raddr   = '0;
    node_wdata   = '0;
    edge_we      = 1'b0;
    edge_re      = 1'b0;
    edge_waddr   = edges_r[EAW-1:0];
    edge_raddr   = e_r[EAW-1:0];
    edge_wdata   = '{tail: in_ch.from_node, head: in_ch.to_node, weight: in_ch.edge_weight};
    eff_d        = DIST_UNREACHED;
    sum          = '0;
    nd           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_v_nxt    = 1'b1;
          o_status_nxt = ST_OK;
          o_dist_nxt   = '0;
          o_par_nxt    = '0;
          o_pval_nxt   = 1'b0;
          o_cnt_nxt    = '0;
          unique case (in_ch.mode)
            MODE_ADD: begin
              if (!a_ok || !b_ok) begin
                o_status_nxt = ST_RANGE;
              end else if (edges_r >= EDGE_LIMIT) begin
                o_status_nxt = ST_FULL;
              end else begin
                edge_we   = 1'b1;
                edges_nxt = edges_r + ECW'(1);
              end
            end
            MODE_CLEAR: begin
              edges_nxt = '0;
            end
            MODE_RUN: begin
              if (!a_ok) begin
                o_status_nxt = ST_RANGE;
              end else begin
                out_v_nxt = 1'b0;
                src_nxt   = in_ch.from_node;
                state_nxt = S_INIT;
              end
            end
            MODE_READ: begin
              if (!a_ok) begin
                o_status_nxt = ST_RANGE;
                o_dist_nxt   = DIST_UNREACHED;
              end else begin
                out_v_nxt  = 1'b0;
                node_re    = 1'b1;
                node_raddr = in_ch.from_node;
                rdidx_nxt  = in_ch.from_node;
                state_nxt  = S_RDOUT;
              end
            end
            default: ;
          endcase
        end
      end

      S_RDOUT: begin
        // an entry not written since the last run start reads as unreached
        out_v_nxt    = 1'b1;
        o_status_nxt = ST_OK;
        o_cnt_nxt    = '0;
        if (valid_r[rdidx_r]) begin
          o_dist_nxt = node_q.path_len;
          o_par_nxt  = node_q.pred;
          o_pval_nxt = node_q.has_pred;
        end else begin
          o_dist_nxt = DIST_UNREACHED;
          o_par_nxt  = '0;
          o_pval_nxt = 1'b0;
        end
        state_nxt = S_IDLE;
      end

      S_INIT: begin
        valid_nxt          = '0;
        valid_nxt[src_r]   = 1'b1;
        settled_nxt        = '0;
        node_we            = 1'b1;
        node_waddr         = src_r;
        node_wdata         = '{path_len: '0, pred: '0, has_pred: 1'b0};
        reached_nxt        = '0;
        i_nxt              = '0;
        best_f_nxt         = 1'b0;
        best_d_nxt         = DIST_UNREACHED;
        state_nxt          = S_SCAN;
      end

      S_SCAN: begin
        // read nodes in index order, keep the first strict minimum
        if (i_r < n_eff) begin
          node_re    = 1'b1;
          node_raddr = i_r[NODE_W-1:0];
          rdidx_nxt  = i_r[NODE_W-1:0];
          rdv_nxt    = 1'b1;
          i_nxt      = i_r + CNT_W'(1);
        end
        if (rdv_r) begin
          eff_d = valid_r[rdidx_r] ? node_q.path_len : DIST_UNREACHED;
          if (!settled_r[rdidx_r] && eff_d < best_d_r) begin
            best_d_nxt   = eff_d;
            best_idx_nxt = rdidx_r;
            best_f_nxt   = 1'b1;
          end
        end else if (i_r >= n_eff) begin
          if (best_f_r) begin
            settled_nxt[best_idx_r] = 1'b1;
            pick_nxt    = best_idx_r;
            pick_d_nxt  = best_d_r;
            reached_nxt = reached_r + CNT_W'(1);
            i_nxt       = '0;
            best_f_nxt  = 1'b0;
            best_d_nxt  = DIST_UNREACHED;
            if (edges_r != '0) begin
              e_nxt     = '0;
              state_nxt = S_EREAD;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_EREAD: begin
        edge_re   = 1'b1;
        state_nxt = S_ECHK;
      end

      S_ECHK: begin
        if (edge_q.tail == pick_r && {1'b0, edge_q.head} < n_eff) begin
          node_re    = 1'b1;
          node_raddr = edge_q.head;
          state_nxt  = S_ECMP;
        end else if (e_r + ECW'(1) == edges_r) begin
          i_nxt     = '0;
          state_nxt = S_SCAN;
        end else begin
          e_nxt     = e_r + ECW'(1);
          state_nxt = S_EREAD;
        end
      end

      S_ECMP: begin
        // relax on strict less-than, path sum saturates below the unreached code
        eff_d = valid_r[edge_q.head] ? node_q.path_len : DIST_UNREACHED;
        sum   = {1'b0, pick_d_r} + {{(DIST_W + 1 - WGT_W){1'b0}}, edge_q.weight};
        nd    = (sum > {1'b0, DIST_CEILING}) ? DIST_CEILING : sum[DIST_W-1:0];
        if (nd < eff_d) begin
          node_we                = 1'b1;
          node_waddr             = edge_q.head;
          node_wdata             = '{path_len: nd, pred: pick_r, has_pred: 1'b1};
          valid_nxt[edge_q.head] = 1'b1;
        end
        if (e_r + ECW'(1) == edges_r) begin
          i_nxt     = '0;
          state_nxt = S_SCAN;
        end else begin
          e_nxt     = e_r + ECW'(1);
          state_nxt = S_EREAD;
        end
      end

      S_DONE: begin
        out_v_nxt    = 1'b1;
        o_status_nxt = ST_OK;
        o_dist_nxt   = '0;
        o_par_nxt    = '0;
        o_pval_nxt   = 1'b0;
        o_cnt_nxt    = reached_r;
        state_nxt    = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      nc_r      <= NODE_LIMIT;
      edges_r   <= '0;
      valid_r   <= '0;
      settled_r <= '0;
      rdv_r     <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      if (cfg_we) begin
        nc_r <= cfg_wdata;
      end
      edges_r   <= edges_nxt;
      valid_r   <= valid_nxt;
      settled_r <= settled_nxt;
      rdv_r     <= rdv_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    rdidx_r    <= rdidx_nxt;
    best_d_r   <= best_d_nxt;
    best_idx_r <= best_idx_nxt;
    best_f_r   <= best_f_nxt;
    pick_r     <= pick_nxt;
    pick_d_r   <= pick_d_nxt;
    reached_r  <= reached_nxt;
    e_r        <= e_nxt;
    src_r      <= src_nxt;
    o_status_r <= o_status_nxt;
    o_dist_r   <= o_dist_nxt;
    o_par_r    <= o_par_nxt;
    o_pval_r   <= o_pval_nxt;
    o_cnt_r    <= o_cnt_nxt;
  end

`ifndef ASSERT_OFF
  // a new transaction is only taken when the result slot is free or draining
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!out_v_r || out_ch.ready))
    else $error("request taken while result slot is occupied");

  // the edge count never runs past the store depth
  a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
    edges_r <= EDGE_LIMIT)
    else $error("edge count beyond store depth");

  // a stored edge bumps the count by exactly one
  a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
    edge_we |=> edges_r == $past(edges_r) + ECW'(1))
    else $error("edge count not advanced on store");

  // a run never reports more settled nodes than are in use
  a_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> reached_r <= n_eff)
    else $error("settled count exceeds node count");
`endif
endmodule
`default_nettype wire

// File: tb/single_source_shortest_path_tb.sv
// Testbench of the single-source shortest path engine: directed table, full edge store, then random phases.
`timescale 1ns / 1ps
module single_source_shortest_path_tb;
  import sssp_pkg::*;

  localparam int EDGE_CAP   = 1024;
  localparam int CYCLE_STOP = 8000000;
  localparam int RAND_ITEMS = 700;

  // one result transaction, as the block reports it
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] distance;
    logic [5:0]  parent;
    logic        pval;
    logic [6:0]  reached;
  } answer_t;

  // directed row: either a register write or a request, optionally with a typed answer
  typedef struct packed {
    logic        is_cfg;
    logic [6:0]  cfg_val;
    logic [1:0]  mode;
    logic [5:0]  a;
    logic [5:0]  b;
    logic [23:0] w;
    logic        typed;
    answer_t     want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [6:0] cfg_wdata;

  sssp_in_if  in_bus ();
  sssp_out_if out_bus ();

  single_source_shortest_path i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the engine: edge list, node table and the node count register
  // ---------------------------------------------------------------------------
  logic [6:0]  m_count;
  logic [5:0]  m_tail [EDGE_CAP];
  logic [5:0]  m_head [EDGE_CAP];
  logic [23:0] m_wgt  [EDGE_CAP];
  int          m_held;
  logic [31:0] m_dist [NODES];
  logic [5:0]  m_pred [NODES];
  logic        m_haspred [NODES];
  logic        m_done [NODES];

  answer_t answers_due[$];
  int      fails;
  int      cycles;
  bit      send_gaps;
  bit      recv_gaps;

  // effective node count: zero acts as one, anything above the table size is clipped
  function automatic int live_count();
    if (m_count == 0) return 1;
    if (m_count > NODE_LIMIT) return NODES;
    return int'(m_count);
  endfunction

  // Dijkstra over the mirrored edge list; settles the smallest (distance, index) first
  function automatic int settle_all(int src, int n);
    int reached;
    int pick;
    logic [31:0] pick_d;
    logic [32:0] sum;
    logic [31:0] nd;
    reached = 0;
    for (int i = 0; i < NODES; i++) begin
      m_dist[i] = DIST_UNREACHED;
      m_pred[i] = '0;
      m_haspred[i] = 1'b0;
      m_done[i] = 1'b0;
    end
    m_dist[src] = '0;
    forever begin
      pick = n;
      pick_d = DIST_UNREACHED;
      for (int i = 0; i < n; i++) begin
        if (!m_done[i] && m_dist[i] < pick_d) begin
          pick_d = m_dist[i];
          pick = i;
        end
      end
      if (pick >= n) break;
      m_done[pick] = 1'b1;
      reached++;
      for (int e = 0; e < m_held; e++) begin
        // stale edges (ends beyond the live count) never match here
        if (int'(m_tail[e]) == pick && int'(m_head[e]) < n) begin
          sum = {1'b0, pick_d} + {9'd0, m_wgt[e]};
          nd = (sum > {1'b0, DIST_CEILING}) ? DIST_CEILING : sum[31:0];
          if (nd < m_dist[m_head[e]]) begin
            m_dist[m_head[e]] = nd;
            m_pred[m_head[e]] = pick[5:0];
            m_haspred[m_head[e]] = 1'b1;
          end
        end
      end
    end
    return reached;
  endfunction

  function automatic answer_t predict(logic [1:0] mode, logic [5:0] a, logic [5:0] b,
                                      logic [23:0] w);
    answer_t r;
    int n;
    r = '0;
    n = live_count();
    case (mode)
      MODE_ADD: begin
        if (int'(a) >= n || int'(b) >= n) begin
          r.status = ST_RANGE;
        end else if (m_held >= EDGE_CAP) begin
          r.status = ST_FULL;
        end else begin
          m_tail[m_held] = a;
          m_head[m_held] = b;
          m_wgt[m_held] = w;
          m_held++;
        end
      end
      MODE_CLEAR: begin
        m_held = 0;
      end
      MODE_RUN: begin
        // out-of-range source leaves the last run's table untouched
        if (int'(a) >= n) r.status = ST_RANGE;
        else r.reached = 7'(settle_all(int'(a), n));
      end
      default: begin
        if (int'(a) >= n) begin
          r.status = ST_RANGE;
          r.distance = DIST_UNREACHED;
        end else begin
          r.distance = m_dist[a];
          r.parent = m_pred[a];
          r.pval = m_haspred[a];
        end
      end
    endcase
    return r;
  endfunction

  // mostly back-to-back, sometimes a short pause, rarely a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_STOP) begin
      $display("[single_source_shortest_path] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // ---------------------------------------------------------------------------
  int stall_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_bus.ready <= 1'b1;
      if (recv_gaps && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // sampled mid-cycle: valid and ready high here means a transaction at the next edge
  always @(negedge clk) begin
    answer_t got;
    answer_t exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.status, out_bus.distance, out_bus.parent_node,
              out_bus.parent_valid, out_bus.reached_count};
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $realtime, got);
        fails++;
      end else begin
        exp_r = answers_due.pop_front();
        if (got.status !== exp_r.status) begin
          $display("%0t: status exp %0d act %0d", $realtime, exp_r.status, got.status);
          fails++;
        end
        if (got.distance !== exp_r.distance) begin
          $display("%0t: distance exp %h act %h", $realtime, exp_r.distance, got.distance);
          fails++;
        end
        if (got.parent !== exp_r.parent) begin
          $display("%0t: parent exp %0d act %0d", $realtime, exp_r.parent, got.parent);
          fails++;
        end
        if (got.pval !== exp_r.pval) begin
          $display("%0t: parent_valid exp %0d act %0d", $realtime, exp_r.pval, got.pval);
          fails++;
        end
        if (got.reached !== exp_r.reached) begin
          $display("%0t: reached exp %0d act %0d", $realtime, exp_r.reached, got.reached);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // valid is left high after a transaction; it drops when a gap follows or when draining
  task automatic send_req(logic [1:0] mode, logic [5:0] a, logic [5:0] b, logic [23:0] w,
                          bit typed, answer_t want);
    int g;
    answer_t pred_r;
    g = send_gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.mode        <= mode;
    in_bus.from_node   <= a;
    in_bus.to_node     <= b;
    in_bus.edge_weight <= w;
    do @(negedge clk); while (!in_bus.ready);
    // transaction happens at the coming edge; the mirror tracks every request
    pred_r = predict(mode, a, b, w);
    answers_due = {answers_due, (typed ? want : pred_r)};
    if (typed && pred_r !== want)
      $display("%0t: table row disagrees with predictor %h / %h", $realtime, want, pred_r);
    @(posedge clk);
  endtask

  // no request outstanding: valid drops and the task waits until every expected result is checked
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(logic [6:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_count = v;
    @(posedge clk);
  endtask

  task automatic send_pred(logic [1:0] mode, logic [5:0] a, logic [5:0] b, logic [23:0] w);
    send_req(mode, a, b, w, 1'b0, '0);
  endtask

  function automatic logic [23:0] pick_weight();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 24'($urandom_range(0, 2047));
    if (roll < 8) return 24'($urandom);
    if (roll < 9) return 24'd0;
    return 24'hFF_FFFF;
  endfunction

  // mostly live nodes, sometimes anything the field can hold
  function automatic logic [5:0] pick_node();
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, live_count() - 1));
  endfunction

  localparam answer_t A_OK    = '{ST_OK, 32'd0, 6'd0, 1'b0, 7'd0};
  localparam answer_t A_FRESH = '{ST_OK, DIST_UNREACHED, 6'd0, 1'b0, 7'd0};
  localparam answer_t A_RANGE = '{ST_RANGE, 32'd0, 6'd0, 1'b0, 7'd0};
  localparam answer_t A_RDOOR = '{ST_RANGE, DIST_UNREACHED, 6'd0, 1'b0, 7'd0};
  localparam answer_t A_ONE   = '{ST_OK, 32'd0, 6'd0, 1'b0, 7'd1};

  // directed table: reads before any run, weight extremes, range errors, count extremes
  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{1'b0, 7'd0,   MODE_READ,  6'd0,  6'd0,  24'd0,        1'b1, A_FRESH},
    '{1'b0, 7'd0,   MODE_READ,  6'd63, 6'd0,  24'd0,        1'b1, A_FRESH},
    '{1'b0, 7'd0,   MODE_RUN,   6'd5,  6'd0,  24'd0,        1'b1, A_ONE},
    '{1'b0, 7'd0,   MODE_ADD,   6'd0,  6'd63, 24'hFF_FFFF,  1'b1, A_OK},
    '{1'b0, 7'd0,   MODE_ADD,   6'd63, 6'd0,  24'd0,        1'b1, A_OK},
    '{1'b0, 7'd0,   MODE_ADD,   6'd5,  6'd0,  24'd1,        1'b1, A_OK},
    '{1'b0, 7'd0,   MODE_ADD,   6'd5,  6'd63, 24'hFF_FFFF,  1'b1, A_OK},
    '{1'b0, 7'd0,   MODE_RUN,   6'd5,  6'd0,  24'd0,        1'b0, A_OK},
    '{1'b0, 7'd0,   MODE_READ,  6'd0,  6'd0,  24'd0,        1'b0, A_OK},
    '{1'b0, 7'd0,   MODE_READ,  6'd63, 6'd0,  24'd0,        1'b0, A_OK},
    '{1'b0, 7'd0,   MODE_READ,  6'd5,  6'd0,  24'd0,        1'b0, A_OK},
    '{1'b0, 7'd0,   MODE_CLEAR, 6'd42, 6'd21, 24'hAA_AAAA,  1'b1, A_OK},
    '{1'b0, 7'd0,   MODE_READ,  6'd63, 6'd0,  24'd0,        1'b0, A_OK},
    '{1'b1, 7'd4,   MODE_ADD,   6'd0,  6'd0,  24'd0,        1'b0, A_OK},
    '{1'b0, 7'd0,   MODE_ADD,   6'd5,  6'd1,  24'd7,        1'b1, A_RANGE},
    '{1'b0, 7'd0,   MODE_ADD,   6'd1,  6'd5,  24'd7,        1'b1, A_RANGE},
    '{1'b0, 7'd0,   MODE_ADD,   6'd0,  6'd3,  24'd300,      1'b1, A_OK},
    '{1'b0, 7'd0,   MODE_RUN,   6'd9,  6'd0,  24'd0,        1'b1, A_RANGE},
    '{1'b0, 7'd0,   MODE_READ,  6'd9,  6'd0,  24'd0,        1'b1, A_RDOOR},
    '{1'b0, 7'd0,   MODE_RUN,   6'd0,  6'd0,  24'd0,        1'b0, A_OK},
    '{1'b0, 7'd0,   MODE_READ,  6'd3,  6'd0,  24'd0,        1'b0, A_OK},
    '{1'b1, 7'd0,   MODE_ADD,   6'd0,  6'd0,  24'd0,        1'b0, A_OK},
    '{1'b0, 7'd0,   MODE_RUN,   6'd0,  6'd0,  24'd0,        1'b1, A_ONE},
    '{1'b1, 7'd127, MODE_ADD,   6'd0,  6'd0,  24'd0,        1'b0, A_OK}
  };

  initial begin
    int sent;
    int k;
    logic [6:0] counts [6];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_ADD;
    in_bus.from_node = '0;
    in_bus.to_node = '0;
    in_bus.edge_weight = '0;
    out_bus.ready = 1'b0;
    fails = 0;
    cycles = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    m_count = NODE_LIMIT;
    m_held = 0;
    for (int i = 0; i < NODES; i++) begin
      m_dist[i] = DIST_UNREACHED;
      m_pred[i] = '0;
      m_haspred[i] = 1'b0;
      m_done[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    foreach (DIR_TAB[r]) begin
      if (DIR_TAB[r].is_cfg) write_count(DIR_TAB[r].cfg_val);
      else send_req(DIR_TAB[r].mode, DIR_TAB[r].a, DIR_TAB[r].b, DIR_TAB[r].w,
                    DIR_TAB[r].typed, DIR_TAB[r].want);
    end
    send_pred(MODE_READ, 6'd63, 6'd0, 24'd0);

    // full edge store: a one-node graph is filled to EDGE_CAP, then one more add must report full
    write_count(7'd1);
    send_pred(MODE_CLEAR, 6'd0, 6'd0, 24'd0);
    for (int e = 0; e < EDGE_CAP; e++) send_pred(MODE_ADD, 6'd0, 6'd0, pick_weight());
    send_req(MODE_ADD, 6'd0, 6'd0, 24'd5, 1'b1, '{ST_FULL, 32'd0, 6'd0, 1'b0, 7'd0});
    send_pred(MODE_RUN, 6'd0, 6'd0, 24'd0);
    send_pred(MODE_READ, 6'd0, 6'd0, 24'd0);
    send_pred(MODE_CLEAR, 6'd0, 6'd0, 24'd0);

    // ---- random phases: load a graph, run from one or two sources, read it back ----
    counts = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd64};
    sent = 0;
    k = 0;
    while (sent < RAND_ITEMS) begin
      write_count(k < 6 ? counts[k] : 7'($urandom_range(1, 64)));
      k++;
      send_gaps = ($urandom_range(0, 4) != 0);
      recv_gaps = ($urandom_range(0, 4) != 0);
      if (m_held > 60 || $urandom_range(0, 3) != 0) begin
        send_pred(MODE_CLEAR, 6'($urandom), 6'($urandom), 24'($urandom));
        sent++;
      end
      repeat ($urandom_range(4, 30)) begin
        if ($urandom_range(0, 19) == 0)
          send_pred(2'($urandom_range(0, 3)), 6'($urandom), 6'($urandom), 24'($urandom));
        else
          send_pred(MODE_ADD, pick_node(), pick_node(), pick_weight());
        sent++;
      end
      repeat ($urandom_range(1, 2)) begin
        send_pred(MODE_RUN, pick_node(), 6'($urandom), 24'($urandom));
        sent++;
        repeat ($urandom_range(3, 12)) begin
          send_pred(MODE_READ, pick_node(), 6'($urandom), 24'($urandom));
          sent++;
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("[single_source_shortest_path] OK");
    end else begin
      $display("[single_source_shortest_path] ERROR");
    end
    $finish;
  end

endmodule
